@@ design/scrb_pkg.sv @@
// shared types, constants and codes for the scrolled hit rectangle builder
`default_nettype none
package scrb_pkg;

   localparam int MAX_DEPTH_DEF = 8;
   localparam int MAX_HITS_DEF  = 64;

   localparam int SCROLL_POS_W    = 16;
   localparam int HIT_CAPACITY_W  = 7;
   localparam int NO_HIT_MASK_W   = 8;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int SLOT_W          = 6;

   localparam logic [SCROLL_POS_W-1:0]   SCROLL_POS_RST    = 16'd0;
   localparam logic [HIT_CAPACITY_W-1:0] HIT_CAPACITY_RST  = 7'd64;
   localparam logic [NO_HIT_MASK_W-1:0]  NO_HIT_MASK_RST   = 8'd1;

   typedef enum logic [1:0] {
      CMD_BEGIN      = 2'd0,
      CMD_END        = 2'd1,
      CMD_SCROLL     = 2'd2,
      CMD_CLIP_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCROLL_POS    = 2'd0,
      CSR_HIT_CAPACITY  = 2'd1,
      CSR_NO_HIT_MASK   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [7:0]  flags;
      logic        in_region;
   } frame_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   typedef struct packed {
      logic [7:0] top;
      logic [7:0] height;
   } region_type;

endpackage
`default_nettype wire

@@ design/scrb_stack.sv @@
// bounded frame stack: push on begin, pop on end, top frame read combinationally
`default_nettype none
module scrb_stack #(
   parameter int MAX_DEPTH = scrb_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire scrb_pkg::stack_ctl_type ctl,
   input  wire scrb_pkg::frame_type push_frame,
   output      scrb_pkg::frame_type top_frame,
   output      logic                full,
   output      logic                empty
);

   localparam int DEP_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   scrb_pkg::frame_type stack_ff [MAX_DEPTH];
   logic [DEP_W-1:0] depth_ff;
   logic [DEP_W-1:0] depth_in;
   logic [DEP_W-1:0] depth_m1;

   assign full     = (depth_ff == DEP_W'(MAX_DEPTH));
   assign empty    = (depth_ff == '0);
   assign depth_m1 = depth_ff - DEP_W'(1);
   assign top_frame = stack_ff[depth_m1[IDX_W-1:0]];

   always_comb begin
      depth_in = depth_ff;
      if (ctl.push) begin
         depth_in = depth_ff + DEP_W'(1);
      end else if (ctl.pop) begin
         depth_in = depth_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // frame storage, no reset: a slot is read only after a push wrote it
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stack_ff[depth_ff[IDX_W-1:0]] <= push_frame;
      end
   end

endmodule
`default_nettype wire

@@ design/scrb_map.sv @@
// maps a popped frame's top and height into screen space inside a scroll region
`default_nettype none
module scrb_map (
   input  wire scrb_pkg::frame_type  frame,
   input  wire scrb_pkg::region_type region,
   input  wire logic [scrb_pkg::SCROLL_POS_W-1:0] scroll_pos,
   output      logic [7:0]           rect_y,
   output      logic [7:0]           rect_h
);

   logic signed [18:0] rtop_s;
   logic signed [18:0] limit_s;
   logic signed [18:0] top_s;
   logic signed [18:0] bottom_s;
   logic signed [18:0] t_s;
   logic signed [18:0] b_s;
   logic signed [18:0] diff_s;

   always_comb begin
      rtop_s   = $signed({11'd0, region.top});
      limit_s  = rtop_s + $signed({11'd0, region.height});
      top_s    = rtop_s + $signed({11'd0, frame.y}) - $signed({3'd0, scroll_pos});
      bottom_s = top_s + $signed({11'd0, frame.h});
      t_s      = (top_s < rtop_s) ? rtop_s : top_s;
      b_s      = (bottom_s > limit_s) ? limit_s : bottom_s;
      // scrolled fully out: zero height at region top
      if (b_s <= t_s) begin
         t_s = rtop_s;
         b_s = rtop_s;
      end
      diff_s = b_s - t_s;
      if (frame.in_region) begin
         rect_y = t_s[7:0];
         rect_h = diff_s[7:0];
      end else begin
         rect_y = frame.y;
         rect_h = frame.h;
      end
   end

endmodule
`default_nettype wire

@@ design/scrolled_hit_rect_builder_top.sv @@
// top level of the scrolled hit rectangle builder
// Takes one event word per clock cycle at a sustained rate while rsp_ready stays high. An
// accepted event is held in an input register, then the stack push or pop, the scroll
// mapping and the capacity check are all done combinationally into the result register,
// so the stack read plus the mapping adders set the clock-to-clock path. A result word that
// waits for rsp_ready holds the next event in the input register and drops req_ready
// until the word is taken. Begin pushes a frame (dropped when MAX_DEPTH frames are
// held); end pops one and emits a rectangle unless its flags hit no_hit_mask or the
// hit table already holds min(hit_capacity, MAX_HITS) entries. The emit count is
// cleared only by reset. Registers are written through the csr port; the user must
// write them only while idle, as the block does not enforce it.
`default_nettype none
module scrolled_hit_rect_builder_top #(
   parameter int MAX_DEPTH = scrb_pkg::MAX_DEPTH_DEF,
   parameter int MAX_HITS  = scrb_pkg::MAX_HITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write port
   input  wire logic        csr_wr_en,
   input  wire logic [scrb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [scrb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // event words in
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_elem_id,
   input  wire logic [7:0]  req_pos_x,
   input  wire logic [7:0]  req_pos_y,
   input  wire logic [7:0]  req_size_w,
   input  wire logic [7:0]  req_size_h,
   input  wire logic [7:0]  req_elem_flag_bits,
   // hit rectangle words out
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_rect_id,
   output      logic [7:0]  rsp_rect_x,
   output      logic [7:0]  rsp_rect_y,
   output      logic [7:0]  rsp_rect_w,
   output      logic [7:0]  rsp_rect_h,
   output      logic [7:0]  rsp_rect_flags,
   output      logic [scrb_pkg::SLOT_W-1:0] rsp_slot_index
);

   localparam int CNT_W = $clog2(MAX_HITS + 1);
   localparam int CMP_W = (CNT_W > scrb_pkg::HIT_CAPACITY_W) ? CNT_W
                                                              : scrb_pkg::HIT_CAPACITY_W;

   // configuration registers
   logic [scrb_pkg::SCROLL_POS_W-1:0]    scroll_pos_ff;
   logic [scrb_pkg::HIT_CAPACITY_W-1:0]  hit_capacity_ff;
   logic [scrb_pkg::NO_HIT_MASK_W-1:0]   no_hit_mask_ff;

   // input register
   logic                a_valid_ff;
   logic                a_valid_in;
   scrb_pkg::cmd_type   a_cmd_ff;
   scrb_pkg::frame_type a_frame_ff;

   // block state
   logic                 scroll_active_ff;
   logic                 scroll_active_in;
   scrb_pkg::region_type region_ff;
   scrb_pkg::region_type region_in;
   logic [CNT_W-1:0]     emit_cnt_ff;
   logic [CNT_W-1:0]     emit_cnt_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rect_id_ff;
   logic [7:0]  rect_x_ff;
   logic [7:0]  rect_y_ff;
   logic [7:0]  rect_w_ff;
   logic [7:0]  rect_h_ff;
   logic [7:0]  rect_flags_ff;
   logic [scrb_pkg::SLOT_W-1:0] slot_ff;

   // processing stage
   logic                    req_accept;
   logic                    go;
   scrb_pkg::stack_ctl_type stk_ctl;
   scrb_pkg::frame_type     push_frame;
   scrb_pkg::frame_type     top_frame;
   logic                    stk_full;
   logic                    stk_empty;
   logic [CMP_W-1:0]        cap;
   logic [CMP_W-1:0]        cap_reg_ext;
   logic [CMP_W-1:0]        cnt_ext;
   logic [CNT_W+scrb_pkg::SLOT_W-1:0] cnt_wide;
   logic                    suppressed;
   logic                    emit;
   logic [7:0]              map_y;
   logic [7:0]              map_h;

   // input side moves on whenever the stage ahead is free or draining
   assign go         = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !a_valid_ff || go;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (go) begin
         a_valid_in = 1'b0;
      end
   end

   // stack control
   always_comb begin
      stk_ctl.push = go && (a_cmd_ff == scrb_pkg::CMD_BEGIN) && !stk_full;
      stk_ctl.pop  = go && (a_cmd_ff == scrb_pkg::CMD_END) && !stk_empty;
      push_frame           = a_frame_ff;
      // mapping is decided by the region state at begin time
      push_frame.in_region = scroll_active_ff;
   end

   scrb_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stk_ctl),
      .push_frame (push_frame),
      .top_frame  (top_frame),
      .full       (stk_full),
      .empty      (stk_empty)
   );

   // region bounds used are the ones current at end time
   scrb_map u_map (
      .frame         (top_frame),
      .region        (region_ff),
      .scroll_pos    (scroll_pos_ff),
      .rect_y        (map_y),
      .rect_h        (map_h)
   );

   // effective capacity is min(hit_capacity, MAX_HITS)
   always_comb begin
      cap_reg_ext = CMP_W'(hit_capacity_ff);
      cap         = (cap_reg_ext < CMP_W'(MAX_HITS)) ? cap_reg_ext : CMP_W'(MAX_HITS);
      cnt_ext     = CMP_W'(emit_cnt_ff);
      cnt_wide    = {{scrb_pkg::SLOT_W{1'b0}}, emit_cnt_ff};
      suppressed  = ((top_frame.flags & no_hit_mask_ff) != '0);
      emit        = stk_ctl.pop && !suppressed && (cnt_ext < cap);
      emit_cnt_in = emit ? (emit_cnt_ff + CNT_W'(1)) : emit_cnt_ff;
   end

   // scroll region state
   always_comb begin
      scroll_active_in = scroll_active_ff;
      region_in        = region_ff;
      if (go) begin
         case (a_cmd_ff)
            scrb_pkg::CMD_SCROLL: begin
               scroll_active_in = 1'b1;
               region_in.top    = a_frame_ff.y;
               region_in.height = a_frame_ff.h;
            end
            scrb_pkg::CMD_CLIP_CLEAR: begin
               // bounds are kept, only the active flag drops
               scroll_active_in = 1'b0;
            end
            default: begin
               scroll_active_in = scroll_active_ff;
            end
         endcase
      end
   end

   // result valid: loaded on each processed event, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         scroll_active_ff <= 1'b0;
         region_ff        <= '0;
         emit_cnt_ff      <= '0;
         scroll_pos_ff    <= scrb_pkg::SCROLL_POS_RST;
         hit_capacity_ff  <= scrb_pkg::HIT_CAPACITY_RST;
         no_hit_mask_ff   <= scrb_pkg::NO_HIT_MASK_RST;
      end else begin
         a_valid_ff       <= a_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         scroll_active_ff <= scroll_active_in;
         region_ff        <= region_in;
         emit_cnt_ff      <= emit_cnt_in;
         if (csr_wr_en) begin
            case (csr_index)
               scrb_pkg::CSR_SCROLL_POS: begin
                  scroll_pos_ff <= csr_wdata[scrb_pkg::SCROLL_POS_W-1:0];
               end
               scrb_pkg::CSR_HIT_CAPACITY: begin
                  hit_capacity_ff <= csr_wdata[scrb_pkg::HIT_CAPACITY_W-1:0];
               end
               scrb_pkg::CSR_NO_HIT_MASK: begin
                  no_hit_mask_ff <= csr_wdata[scrb_pkg::NO_HIT_MASK_W-1:0];
               end
               default: begin
                  // unused index, write dropped
               end
            endcase
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_cmd_ff             <= scrb_pkg::cmd_type'(req_command);
         a_frame_ff.id        <= req_elem_id;
         a_frame_ff.x         <= req_pos_x;
         a_frame_ff.y         <= req_pos_y;
         a_frame_ff.w         <= req_size_w;
         a_frame_ff.h         <= req_size_h;
         a_frame_ff.flags     <= req_elem_flag_bits;
         a_frame_ff.in_region <= 1'b0;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         rect_id_ff    <= top_frame.id;
         rect_x_ff     <= top_frame.x;
         rect_y_ff     <= map_y;
         rect_w_ff     <= top_frame.w;
         rect_h_ff     <= map_h;
         rect_flags_ff <= top_frame.flags;
         slot_ff       <= cnt_wide[scrb_pkg::SLOT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rect_id    = rect_id_ff;
   assign rsp_rect_x     = rect_x_ff;
   assign rsp_rect_y     = rect_y_ff;
   assign rsp_rect_w     = rect_w_ff;
   assign rsp_rect_h     = rect_h_ff;
   assign rsp_rect_flags = rect_flags_ff;
   assign rsp_slot_index = slot_ff;

endmodule
`default_nettype wire

@@ design/scrb_checker.sv @@
// port-level checks for the scrolled hit rectangle builder, bound to the top level
`default_nettype none
module scrb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_rect_id,
   input wire logic [7:0]  rsp_rect_x,
   input wire logic [7:0]  rsp_rect_y,
   input wire logic [7:0]  rsp_rect_w,
   input wire logic [7:0]  rsp_rect_h,
   input wire logic [7:0]  rsp_rect_flags,
   input wire logic [scrb_pkg::SLOT_W-1:0] rsp_slot_index
);

   logic                        have_last_ff;
   logic [scrb_pkg::SLOT_W-1:0] last_slot_ff;
   logic [scrb_pkg::SLOT_W-1:0] next_slot;

   assign next_slot = last_slot_ff + scrb_pkg::SLOT_W'(1);

   // remember the slot of the last word taken
   always_ff @(posedge clock) begin
      if (reset) begin
         have_last_ff <= 1'b0;
         last_slot_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         have_last_ff <= 1'b1;
         last_slot_ff <= rsp_slot_index;
      end
   end

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rect_id) && $stable(rsp_rect_x)
         && $stable(rsp_rect_y) && $stable(rsp_rect_w) && $stable(rsp_rect_h)
         && $stable(rsp_rect_flags) && $stable(rsp_slot_index))
      else $error("result word changed while stalled");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result needs an event taken earlier and held first in the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching event");

   // table slots are handed out in order
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && have_last_ff |-> rsp_slot_index == next_slot)
      else $error("slot index out of sequence");

endmodule

bind scrolled_hit_rect_builder_top scrb_checker u_scrb_checker (.*);
`default_nettype wire

@@ dv/scrolled_hit_rect_builder_top_tb.sv @@
// self-checking testbench for the scrolled hit rectangle builder top level
`timescale 1ns / 100ps
module scrolled_hit_rect_builder_top_tb;

   // run length guard and quiet time after the last word
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PRINT_LIMIT   = 50;

   // one event word as it goes into the block
   typedef struct {
      scrb_pkg::cmd_type cmd;
      logic [15:0] id;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [7:0]  flags;
   } event_word_type;

   // one hit rectangle word as it should come out
   typedef struct {
      logic [15:0] id;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [7:0]  flags;
      logic [5:0]  slot;
   } hit_rect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [scrb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [scrb_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [15:0] req_elem_id = '0;
   logic [7:0]  req_pos_x = '0;
   logic [7:0]  req_pos_y = '0;
   logic [7:0]  req_size_w = '0;
   logic [7:0]  req_size_h = '0;
   logic [7:0]  req_elem_flag_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_rect_id;
   logic [7:0]  rsp_rect_x;
   logic [7:0]  rsp_rect_y;
   logic [7:0]  rsp_rect_w;
   logic [7:0]  rsp_rect_h;
   logic [7:0]  rsp_rect_flags;
   logic [scrb_pkg::SLOT_W-1:0] rsp_slot_index;

   scrolled_hit_rect_builder_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_elem_id        (req_elem_id),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_size_w         (req_size_w),
      .req_size_h         (req_size_h),
      .req_elem_flag_bits (req_elem_flag_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rect_id        (rsp_rect_id),
      .rsp_rect_x         (rsp_rect_x),
      .rsp_rect_y         (rsp_rect_y),
      .rsp_rect_w         (rsp_rect_w),
      .rsp_rect_h         (rsp_rect_h),
      .rsp_rect_flags     (rsp_rect_flags),
      .rsp_slot_index     (rsp_slot_index)
   );

   always #2 clock = ~clock;

   // words waiting to be sent, and rectangles owed by the block
   event_word_type event_backlog[$];
   hit_rect_type   rects_in_flight[$];

   // shadow of the control registers
   logic [15:0] ofs_reg  = scrb_pkg::SCROLL_POS_RST;
   logic [6:0]  cap_reg  = scrb_pkg::HIT_CAPACITY_RST;
   logic [7:0]  mask_reg = scrb_pkg::NO_HIT_MASK_RST;

   // shadow of the element stack, region and hit table fill
   scrb_pkg::frame_type  frame_mem [scrb_pkg::MAX_DEPTH_DEF];
   int                   stack_level = 0;
   int                   emitted_rects = 0;
   logic                 region_on = 1'b0;
   scrb_pkg::region_type cur_region = '0;

   // handshake seen at the last rising edge, idle knobs, bookkeeping
   logic        req_fire = 1'b0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          err_count = 0;
   int          cycle_count = 0;

   task automatic report_mismatch(string msg);
      if (err_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic field_check(string nm, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", nm, got, want));
   endtask

   // advance the shadow state by one accepted event word
   function automatic void build_hit_rect(event_word_type ev);
      scrb_pkg::frame_type f;
      hit_rect_type r;
      int rtop, top_v, bot, lim, t, hv, cap_eff;
      case (ev.cmd)
         scrb_pkg::CMD_BEGIN: begin
            // a push on a full stack is dropped
            if (stack_level < scrb_pkg::MAX_DEPTH_DEF) begin
               f.id = ev.id;
               f.x = ev.x;
               f.y = ev.y;
               f.w = ev.w;
               f.h = ev.h;
               f.flags = ev.flags;
               f.in_region = region_on;
               frame_mem[stack_level] = f;
               stack_level++;
            end
         end
         scrb_pkg::CMD_SCROLL: begin
            region_on = 1'b1;
            cur_region.top = ev.y;
            cur_region.height = ev.h;
         end
         scrb_pkg::CMD_CLIP_CLEAR: region_on = 1'b0;
         scrb_pkg::CMD_END: begin
            if (stack_level != 0) begin
               stack_level--;
               f = frame_mem[stack_level];
               cap_eff = (int'(cap_reg) < scrb_pkg::MAX_HITS_DEF) ? int'(cap_reg)
                                                                  : scrb_pkg::MAX_HITS_DEF;
               if ((f.flags & mask_reg) == 8'd0 && emitted_rects < cap_eff) begin
                  r.id = f.id;
                  r.x = f.x;
                  r.y = f.y;
                  r.w = f.w;
                  r.h = f.h;
                  r.flags = f.flags;
                  r.slot = emitted_rects[5:0];
                  // mapping was decided at push time, the region is the current one
                  if (f.in_region) begin
                     rtop = int'(cur_region.top);
                     top_v = rtop + int'(f.y) - int'(ofs_reg);
                     bot = top_v + int'(f.h);
                     lim = rtop + int'(cur_region.height);
                     t = (top_v < rtop) ? rtop : top_v;
                     if (bot > lim) bot = lim;
                     // scrolled fully out: zero height at the region top
                     if (bot <= t) begin
                        t = rtop;
                        bot = rtop;
                     end
                     hv = bot - t;
                     r.y = t[7:0];
                     r.h = hv[7:0];
                  end
                  rects_in_flight.push_back(r);
                  emitted_rects++;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // rising edge: check result words, then log the accepted event word
   always @(posedge clock) begin
      hit_rect_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rects_in_flight.size() == 0) begin
               report_mismatch($sformatf("rect word id %h with none owed", rsp_rect_id));
            end else begin
               want = rects_in_flight.pop_front();
               field_check("rect_id", rsp_rect_id, want.id);
               field_check("rect_x", 16'(rsp_rect_x), 16'(want.x));
               field_check("rect_y", 16'(rsp_rect_y), 16'(want.y));
               field_check("rect_w", 16'(rsp_rect_w), 16'(want.w));
               field_check("rect_h", 16'(rsp_rect_h), 16'(want.h));
               field_check("rect_flags", 16'(rsp_rect_flags), 16'(want.flags));
               field_check("slot_index", 16'(rsp_slot_index), 16'(want.slot));
            end
         end
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            build_hit_rect('{scrb_pkg::cmd_type'(req_command), req_elem_id, req_pos_x,
                             req_pos_y, req_size_w, req_size_h, req_elem_flag_bits});
         end
      end
   end

   // falling edge: hold, load or drop the event word; roll the result stall
   always @(negedge clock) begin
      event_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && !req_fire) begin
            // word still waiting, keep it steady
         end else if (event_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = event_backlog.pop_front();
            req_valid <= 1'b1;
            req_command <= nxt.cmd;
            req_elem_id <= nxt.id;
            req_pos_x <= nxt.x;
            req_pos_y <= nxt.y;
            req_size_w <= nxt.w;
            req_size_h <= nxt.h;
            req_elem_flag_bits <= nxt.flags;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("scrolled_hit_rect_builder_top verification failed");
         $finish;
      end
   end

   task automatic push_event(scrb_pkg::cmd_type cmd, logic [15:0] id, logic [7:0] x,
                             logic [7:0] y, logic [7:0] w, logic [7:0] h, logic [7:0] flags);
      event_backlog.push_back('{cmd, id, x, y, w, h, flags});
   endtask

   // geometry leaning toward small values so regions clip partially
   function automatic logic [7:0] geom_byte();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 60));
   endfunction

   task automatic push_scroll_region();
      push_event(scrb_pkg::CMD_SCROLL, 16'($urandom_range(0, 65535)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), geom_byte(), 8'($urandom_range(0, 255)));
   endtask

   // mostly nested begin/end groups with random content, some loose noise words
   task automatic add_random_events(int n);
      int base, k, j;
      base = event_backlog.size();
      while (event_backlog.size() - base < n) begin
         if ($urandom_range(0, 9) < 3) begin
            push_event(scrb_pkg::cmd_type'($urandom_range(0, 3)),
                       16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 2) == 0) push_scroll_region();
            else if ($urandom_range(0, 4) == 0)
               push_event(scrb_pkg::CMD_CLIP_CLEAR, '0, '0, '0, '0, '0, '0);
            // now and then a group deeper than the stack
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 5);
            for (j = 0; j < k; j++) begin
               push_event(scrb_pkg::CMD_BEGIN, 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)), geom_byte(),
                          8'($urandom_range(0, 255)), geom_byte(),
                          8'($urandom_range(0, 255)));
               if ($urandom_range(0, 9) == 0) push_scroll_region();
            end
            for (j = 0; j < k; j++) begin
               // region may move while frames are open
               if ($urandom_range(0, 9) == 0) push_scroll_region();
               push_event(scrb_pkg::CMD_END, 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic write_csr(scrb_pkg::csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         scrb_pkg::CSR_SCROLL_POS:   ofs_reg = val;
         scrb_pkg::CSR_HIT_CAPACITY: cap_reg = val[6:0];
         scrb_pkg::CSR_NO_HIT_MASK:  mask_reg = val[7:0];
         default: ;
      endcase
   endtask

   // all words sent, all rectangles back, then let ignored words flush
   task automatic wait_drained();
      while (event_backlog.size() != 0 || req_valid || rects_in_flight.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int snd_idle, int rcv_stall, logic [15:0] ofs, logic [15:0] cap,
                            logic [15:0] mask, int n_items);
      wait_drained();
      write_csr(scrb_pkg::CSR_SCROLL_POS, ofs);
      write_csr(scrb_pkg::CSR_HIT_CAPACITY, cap);
      write_csr(scrb_pkg::CSR_NO_HIT_MASK, mask);
      send_idle_pct = snd_idle;
      rsp_stall_pct = rcv_stall;
      @(posedge clock);
      add_random_events(n_items);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values written back explicitly
      write_csr(scrb_pkg::CSR_SCROLL_POS, 16'(scrb_pkg::SCROLL_POS_RST));
      write_csr(scrb_pkg::CSR_HIT_CAPACITY, 16'(scrb_pkg::HIT_CAPACITY_RST));
      write_csr(scrb_pkg::CSR_NO_HIT_MASK, 16'(scrb_pkg::NO_HIT_MASK_RST));
      @(posedge clock);

      // directed: pop on empty stack, clip clear with nothing open
      push_event(scrb_pkg::CMD_END, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_event(scrb_pkg::CMD_CLIP_CLEAR, '0, '0, '0, '0, '0, '0);
      // unmapped frames at the field extremes, then a suppressed one
      push_event(scrb_pkg::CMD_BEGIN, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE);
      push_event(scrb_pkg::CMD_BEGIN, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(scrb_pkg::CMD_BEGIN, 16'h1234, 8'h11, 8'h22, 8'h33, 8'h44, 8'h01);
      // region 10..60: inside, clipped at the bottom, scrolled fully out
      push_event(scrb_pkg::CMD_SCROLL, '0, '0, 8'd10, '0, 8'd50, '0);
      push_event(scrb_pkg::CMD_BEGIN, 16'h00D0, 8'd4, 8'd5, 8'd6, 8'd20, 8'h02);
      push_event(scrb_pkg::CMD_BEGIN, 16'h00E0, 8'd7, 8'd0, 8'd9, 8'd255, 8'h04);
      push_event(scrb_pkg::CMD_BEGIN, 16'h00F0, 8'd1, 8'd100, 8'd2, 8'd10, 8'h08);
      // after clip clear new frames are unmapped, open ones stay mapped
      push_event(scrb_pkg::CMD_CLIP_CLEAR, '0, '0, '0, '0, '0, '0);
      push_event(scrb_pkg::CMD_BEGIN, 16'h0A0A, 8'd3, 8'd7, 8'd5, 8'd3, 8'h10);
      push_event(scrb_pkg::CMD_BEGIN, 16'h0B0B, 8'd8, 8'd9, 8'd10, 8'd11, 8'h20);
      // stack holds eight frames now, this push is dropped
      push_event(scrb_pkg::CMD_BEGIN, 16'hDEAD, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h00);
      repeat (9) push_event(scrb_pkg::CMD_END, '0, '0, '0, '0, '0, '0);
      // high region top, result top wraps past 8 bits
      push_event(scrb_pkg::CMD_SCROLL, '0, '0, 8'd200, '0, 8'd255, '0);
      push_event(scrb_pkg::CMD_BEGIN, 16'h5A5A, 8'd12, 8'd200, 8'd34, 8'd100, 8'h40);
      push_event(scrb_pkg::CMD_END, '0, '0, '0, '0, '0, '0);

      // random phases: idle pattern, offset, capacity, mask, length
      run_phase(0, 0, 16'hFFFF, 16'd0, 16'h00, 80);
      run_phase(0, 0, 16'd0, 16'd20, 16'h01, 150);
      run_phase(78, 0, 16'd37, 16'd34, 16'h80, 140);
      run_phase(0, 78, 16'd200, 16'd48, 16'h20, 140);
      run_phase(7, 7, 16'd90, 16'd127, 16'h00, 140);
      run_phase(0, 0, 16'd255, 16'd64, 16'hFF, 100);

      wait_drained();
      if (err_count == 0) begin
         $display("scrolled_hit_rect_builder_top verification clean");
      end else begin
         $display("scrolled_hit_rect_builder_top verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/scrb_pkg.sv
design/scrb_stack.sv
design/scrb_map.sv
design/scrolled_hit_rect_builder_top.sv
design/scrb_checker.sv
dv/scrolled_hit_rect_builder_top_tb.sv
